>>> design/ise_pkg.sv
package ise_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SQRT_LAT   = 32;
  localparam int DIV_LAT    = 32;
  localparam int NORM_SHIFT = 30;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERTURB_TOL = 3'd3;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] surface_value;
    logic signed [47:0] perturbed_value;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               on_axis;
    logic               zero_gradient;
    logic               saturated;
  } out_res_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic hit32(input logic signed [35:0] v);
    return v[35:31] != {5{v[31]}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (hit32(v)) begin
      return v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic hit48(input logic signed [67:0] v);
    return v[67:47] != {21{v[47]}};
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [67:0] v);
    if (hit48(v)) begin
      return v[67] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
    end
    return v[47:0];
  endfunction

endpackage

>>> design/ise_sqrt.sv
module ise_sqrt import ise_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  output logic        out_valid,
  output logic [31:0] root
);

  logic [63:0] n_r   [SQRT_LAT];
  logic [63:0] res_r [SQRT_LAT];
  logic        v_r   [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_in, res_in, n_nxt, res_nxt;
    logic        v_in;
    logic [64:0] trial;

    if (k == 0) begin : g_first
      assign n_in   = radicand;
      assign res_in = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign n_in   = n_r[k-1];
      assign res_in = res_r[k-1];
      assign v_in   = v_r[k-1];
    end

    always_comb begin
      trial = {1'b0, res_in} + {1'b0, BIT};
      if ({1'b0, n_in} >= trial) begin
        n_nxt   = n_in - trial[63:0];
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      n_r[k]   <= n_nxt;
      res_r[k] <= res_nxt;
    end
  end

  assign out_valid = v_r[SQRT_LAT-1];
  assign root      = res_r[SQRT_LAT-1][31:0];

endmodule

>>> design/ise_div.sv
module ise_div import ise_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        out_valid,
  output logic [31:0] quotient
);

  logic [31:0] rem_r [DIV_LAT];
  logic [31:0] lo_r  [DIV_LAT];
  logic [31:0] q_r   [DIV_LAT];
  logic [31:0] d_r   [DIV_LAT];
  logic        v_r   [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [31:0] rem_in, lo_in, q_in, d_in, rem_nxt;
    logic        v_in, q_bit;
    logic [32:0] t;

    if (k == 0) begin : g_first
      assign rem_in = dividend[63:32];
      assign lo_in  = dividend[31:0];
      assign q_in   = '0;
      assign d_in   = divisor;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
      assign d_in   = d_r[k-1];
      assign v_in   = v_r[k-1];
    end

    always_comb begin
      t = {rem_in, lo_in[31]};
      if (t >= {1'b0, d_in}) begin
        rem_nxt = 32'(t - {1'b0, d_in});
        q_bit   = 1'b1;
      end else begin
        rem_nxt = t[31:0];
        q_bit   = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      rem_r[k] <= rem_nxt;
      lo_r[k]  <= {lo_in[30:0], 1'b0};
      q_r[k]   <= {q_in[30:0], q_bit};
      d_r[k]   <= d_in;
    end
  end

  assign out_valid = v_r[DIV_LAT-1];
  assign quotient  = q_r[DIV_LAT-1];

endmodule

>>> design/implicit_surface_eval_normal.sv
// Evaluates the implicit surface value, its perturbed copy, the gradient and the unit normal
// for one point per clock. A request is taken whenever start is high (busy stays low) and its
// result shows on out_res with out_valid in request order; the receiver cannot stall, so every
// result must be taken in the cycle it appears. The pipeline holds four chained 32-stage
// bit-per-stage units: the radius square root, the radial divide, the gradient-length square
// root and the normal divide. Coefficients must be written only while idle; the block does not enforce it.
module implicit_surface_eval_normal import ise_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  output logic                 out_valid,
  output out_res_t             out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef struct packed {
    in_req_t     p;
    logic [31:0] r;
  } pr_t;

  typedef struct packed {
    logic signed [47:0] surface;
    logic signed [47:0] perturbed;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic [31:0]        su0;
    logic [31:0]        su1;
    logic [31:0]        su2;
    logic               on_axis;
    logic               zg;
    logic               sat;
  } nsb_t;

  // configuration
  logic signed [31:0] coeff_a_r, coeff_b_r, coeff_c_r;
  logic [15:0]        perturb_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a_r     <= '0;
      coeff_b_r     <= '0;
      coeff_c_r     <= '0;
      perturb_tol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFF_A:     coeff_a_r     <= cfg_data;
        REG_COEFF_B:     coeff_b_r     <= cfg_data;
        REG_COEFF_C:     coeff_c_r     <= cfg_data;
        REG_PERTURB_TOL: perturb_tol_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ua, ub, uc;
  assign ua   = mag32(coeff_a_r);
  assign ub   = mag32(coeff_b_r);
  assign uc   = mag32(coeff_c_r);
  assign busy = 1'b0;

  // radius squared
  logic        v0_r, v1_r, v2_r;
  in_req_t     p0_r, p1_r, p2_r;
  logic [63:0] xsq_r, ysq_r, sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    p0_r  <= in_req;
    p1_r  <= p0_r;
    p2_r  <= p1_r;
    xsq_r <= mag32(p0_r.x_coord) * mag32(p0_r.x_coord);
    ysq_r <= mag32(p0_r.y_coord) * mag32(p0_r.y_coord);
    sum_r <= xsq_r + ysq_r;
  end

  logic        rv;
  logic [31:0] r_root;

  ise_sqrt u_sqrt_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .radicand  (sum_r),
    .out_valid (rv),
    .root      (r_root)
  );

  in_req_t dl_a_r [SQRT_LAT];
  always_ff @(posedge clk) begin
    dl_a_r[0] <= p2_r;
    for (int i = 1; i < SQRT_LAT; i++) dl_a_r[i] <= dl_a_r[i-1];
  end

  // radial products
  logic        v3_r;
  pr_t         pr3_r;
  logic [63:0] nax_r, nay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= rv;
    end
    pr3_r.p <= dl_a_r[SQRT_LAT-1];
    pr3_r.r <= r_root;
    nax_r   <= ua * mag32(dl_a_r[SQRT_LAT-1].x_coord);
    nay_r   <= ua * mag32(dl_a_r[SQRT_LAT-1].y_coord);
  end

  logic        qv;
  logic [31:0] qx, qy;

  ise_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .dividend  (nax_r),
    .divisor   (pr3_r.r),
    .out_valid (qv),
    .quotient  (qx)
  );

  ise_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .dividend  (nay_r),
    .divisor   (pr3_r.r),
    .out_valid (),
    .quotient  (qy)
  );

  pr_t dl_b_r [DIV_LAT];
  always_ff @(posedge clk) begin
    dl_b_r[0] <= pr3_r;
    for (int i = 1; i < DIV_LAT; i++) dl_b_r[i] <= dl_b_r[i-1];
  end

  // gradient and value terms
  pr_t                pb;
  logic               on_ax;
  logic signed [35:0] x36, y36, z36, b36, rad_x, rad_y, gx_full, gy_full, gz_full;
  logic signed [33:0] dd;
  logic [32:0]        mag_d;

  assign pb = dl_b_r[DIV_LAT-1];

  always_comb begin
    on_ax   = (pb.r == '0);
    x36     = 36'(pb.p.x_coord);
    y36     = 36'(pb.p.y_coord);
    z36     = 36'(pb.p.z_coord);
    b36     = 36'(coeff_b_r);
    rad_x   = $signed({4'd0, qx});
    rad_y   = $signed({4'd0, qy});
    if (coeff_a_r[31] ^ pb.p.x_coord[31]) rad_x = -rad_x;
    if (coeff_a_r[31] ^ pb.p.y_coord[31]) rad_y = -rad_y;
    if (on_ax) begin
      rad_x = '0;
      rad_y = '0;
    end
    gx_full = (x36 <<< 1) - (rad_x <<< 1) + b36;
    gy_full = (y36 <<< 1) - (rad_y <<< 1);
    gz_full = z36 <<< 1;
    dd      = 34'(coeff_a_r) - $signed({2'b00, pb.r});
    mag_d   = dd[33] ? 33'(-dd) : dd[32:0];
  end

  logic               v4_r;
  logic signed [31:0] gx4_r, gy4_r, gz4_r;
  logic               gsat4_r, on_ax4_r, bxn4_r;
  logic [32:0]        magd4_r;
  logic [63:0]        zsq4_r, bx4_r, csq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= qv;
    end
    gx4_r    <= sat32(gx_full);
    gy4_r    <= sat32(gy_full);
    gz4_r    <= sat32(gz_full);
    gsat4_r  <= hit32(gx_full) | hit32(gy_full) | hit32(gz_full);
    on_ax4_r <= on_ax;
    magd4_r  <= mag_d;
    zsq4_r   <= mag32(pb.p.z_coord) * mag32(pb.p.z_coord);
    bx4_r    <= ub * mag32(pb.p.x_coord);
    bxn4_r   <= coeff_b_r[31] ^ pb.p.x_coord[31];
    csq4_r   <= uc * uc;
  end

  // partial products and normalising shift
  logic [31:0] u0, u1, u2, mx;
  logic [4:0]  shamt;

  always_comb begin
    u0    = mag32(gx4_r);
    u1    = mag32(gy4_r);
    u2    = mag32(gz4_r);
    mx    = (u0 > u1) ? u0 : u1;
    mx    = (u2 > mx) ? u2 : mx;
    shamt = '0;
    for (int i = 0; i < NORM_SHIFT; i++) begin
      if (mx[i]) shamt = 5'(NORM_SHIFT - i);
    end
    if (|mx[31:NORM_SHIFT]) shamt = '0;
  end

  logic               v5_r;
  logic [31:0]        hh5_r;
  logic [32:0]        hl5_r;
  logic [33:0]        ll5_r;
  logic [63:0]        zsq5_r, bx5_r, csq5_r;
  logic               bxn5_r, gsat5_r, on_ax5_r, zg5_r;
  logic signed [31:0] gx5_r, gy5_r, gz5_r;
  logic [31:0]        u0_5_r, u1_5_r, u2_5_r;
  logic [4:0]         sh5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    hh5_r    <= magd4_r[32:17] * magd4_r[32:17];
    hl5_r    <= magd4_r[32:17] * magd4_r[16:0];
    ll5_r    <= magd4_r[16:0] * magd4_r[16:0];
    zsq5_r   <= zsq4_r;
    bx5_r    <= bx4_r;
    csq5_r   <= csq4_r;
    bxn5_r   <= bxn4_r;
    gsat5_r  <= gsat4_r;
    on_ax5_r <= on_ax4_r;
    zg5_r    <= (mx == '0);
    gx5_r    <= gx4_r;
    gy5_r    <= gy4_r;
    gz5_r    <= gz4_r;
    u0_5_r   <= u0;
    u1_5_r   <= u1;
    u2_5_r   <= u2;
    sh5_r    <= shamt;
  end

  logic               v6_r;
  logic [65:0]        dsq6_r;
  logic [63:0]        zsq6_r, bx6_r, csq6_r;
  logic               bxn6_r, gsat6_r, on_ax6_r, zg6_r;
  logic signed [31:0] gx6_r, gy6_r, gz6_r;
  logic [31:0]        su0_6_r, su1_6_r, su2_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    dsq6_r   <= (66'(hh5_r) << 34) + (66'(hl5_r) << 18) + 66'(ll5_r);
    zsq6_r   <= zsq5_r;
    bx6_r    <= bx5_r;
    csq6_r   <= csq5_r;
    bxn6_r   <= bxn5_r;
    gsat6_r  <= gsat5_r;
    on_ax6_r <= on_ax5_r;
    zg6_r    <= zg5_r;
    gx6_r    <= gx5_r;
    gy6_r    <= gy5_r;
    gz6_r    <= gz5_r;
    su0_6_r  <= u0_5_r << sh5_r;
    su1_6_r  <= u1_5_r << sh5_r;
    su2_6_r  <= u2_5_r << sh5_r;
  end

  logic signed [67:0] bx_s;
  assign bx_s = bxn6_r ? -$signed({4'd0, bx6_r}) : $signed({4'd0, bx6_r});

  logic               v7_r;
  logic signed [67:0] acc7_r;
  logic [63:0]        sq0_7_r, sq1_7_r, sq2_7_r;
  logic               gsat7_r, on_ax7_r, zg7_r;
  logic signed [31:0] gx7_r, gy7_r, gz7_r;
  logic [31:0]        su0_7_r, su1_7_r, su2_7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    acc7_r   <= $signed({2'b00, dsq6_r}) + $signed({4'd0, zsq6_r}) + bx_s
                - $signed({4'd0, csq6_r});
    sq0_7_r  <= su0_6_r * su0_6_r;
    sq1_7_r  <= su1_6_r * su1_6_r;
    sq2_7_r  <= su2_6_r * su2_6_r;
    gsat7_r  <= gsat6_r;
    on_ax7_r <= on_ax6_r;
    zg7_r    <= zg6_r;
    gx7_r    <= gx6_r;
    gy7_r    <= gy6_r;
    gz7_r    <= gz6_r;
    su0_7_r  <= su0_6_r;
    su1_7_r  <= su1_6_r;
    su2_7_r  <= su2_6_r;
  end

  logic signed [67:0] f_sh, p_sh;
  assign f_sh = acc7_r >>> FRAC_BITS;
  assign p_sh = (acc7_r + $signed(68'(perturb_tol_r) << FRAC_BITS)) >>> FRAC_BITS;

  logic        v8_r;
  nsb_t        nsb8_r;
  logic [63:0] sumsq8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    nsb8_r.surface   <= sat48(f_sh);
    nsb8_r.perturbed <= sat48(p_sh);
    nsb8_r.gx        <= gx7_r;
    nsb8_r.gy        <= gy7_r;
    nsb8_r.gz        <= gz7_r;
    nsb8_r.su0       <= su0_7_r;
    nsb8_r.su1       <= su1_7_r;
    nsb8_r.su2       <= su2_7_r;
    nsb8_r.on_axis   <= on_ax7_r;
    nsb8_r.zg        <= zg7_r;
    nsb8_r.sat       <= gsat7_r | hit48(f_sh) | hit48(p_sh);
    sumsq8_r         <= sq0_7_r + sq1_7_r + sq2_7_r;
  end

  // gradient length and normal
  logic        mv;
  logic [31:0] m_len;

  ise_sqrt u_sqrt_m (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v8_r),
    .radicand  (sumsq8_r),
    .out_valid (mv),
    .root      (m_len)
  );

  nsb_t dl_c_r [SQRT_LAT];
  always_ff @(posedge clk) begin
    dl_c_r[0] <= nsb8_r;
    for (int i = 1; i < SQRT_LAT; i++) dl_c_r[i] <= dl_c_r[i-1];
  end

  nsb_t pc;
  assign pc = dl_c_r[SQRT_LAT-1];

  logic        nv;
  logic [31:0] q0, q1, q2;

  ise_div u_div_n0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mv),
    .dividend  (64'(pc.su0) << NORM_SHIFT),
    .divisor   (m_len),
    .out_valid (nv),
    .quotient  (q0)
  );

  ise_div u_div_n1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mv),
    .dividend  (64'(pc.su1) << NORM_SHIFT),
    .divisor   (m_len),
    .out_valid (),
    .quotient  (q1)
  );

  ise_div u_div_n2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mv),
    .dividend  (64'(pc.su2) << NORM_SHIFT),
    .divisor   (m_len),
    .out_valid (),
    .quotient  (q2)
  );

  nsb_t dl_d_r [DIV_LAT];
  always_ff @(posedge clk) begin
    dl_d_r[0] <= pc;
    for (int i = 1; i < DIV_LAT; i++) dl_d_r[i] <= dl_d_r[i-1];
  end

  nsb_t     pd;
  out_res_t res_nxt;

  assign pd = dl_d_r[DIV_LAT-1];

  always_comb begin
    res_nxt.surface_value   = pd.surface;
    res_nxt.perturbed_value = pd.perturbed;
    res_nxt.grad_x          = pd.gx;
    res_nxt.grad_y          = pd.gy;
    res_nxt.grad_z          = pd.gz;
    res_nxt.normal_x        = pd.gx[31] ? (~q0 + 32'd1) : q0;
    res_nxt.normal_y        = pd.gy[31] ? (~q1 + 32'd1) : q1;
    res_nxt.normal_z        = pd.gz[31] ? (~q2 + 32'd1) : q2;
    if (pd.zg) begin
      res_nxt.normal_x = '0;
      res_nxt.normal_y = '0;
      res_nxt.normal_z = '0;
    end
    res_nxt.on_axis         = pd.on_axis;
    res_nxt.zero_gradient   = pd.zg;
    res_nxt.saturated       = pd.sat;
  end

  logic     out_valid_r;
  out_res_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= nv;
    end
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
